[design/dtq_pkg.sv]
// dtq_pkg: shared types and constants for the deadline timer queue.
// Used by dtq_cell, deadline_timer_queue and dtq_checker. No dependencies.
package dtq_pkg;

    localparam int SLOT_W        = 4;
    localparam int TIME_W        = 63;
    localparam int REQ_W         = 2;
    localparam int DEF_NUM_SLOTS = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_SCHED_ABS = 2'd0,
        REQ_SCHED_REL = 2'd1,
        REQ_ABORT     = 2'd2,
        REQ_TICK      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_INSERT = 2'd2,
        OP_POP    = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_INSERT = 2'd1,
        ST_TICK   = 2'd2
    } state_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] key_slot;
        logic [SLOT_W-1:0] new_slot;
        logic [TIME_W-1:0] new_deadline;
        logic [TIME_W-1:0] now;
    } cell_ctrl_t;

endpackage

[design/dtq_cell.sv]
// dtq_cell: one queue position holding a slot and its deadline.
// Depends on dtq_pkg. Exchanges entries with its two neighbors.
module dtq_cell
    import dtq_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic              occ,
    input  logic [SLOT_W-1:0] prev_slot,
    input  logic [TIME_W-1:0] prev_deadline,
    input  logic              prev_take,
    input  logic [SLOT_W-1:0] next_slot,
    input  logic [TIME_W-1:0] next_deadline,
    input  logic              hit_in,
    output logic [SLOT_W-1:0] slot,
    output logic [TIME_W-1:0] deadline,
    output logic              take,
    output logic              hit_out,
    output logic              due
);

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] deadline_next;
    logic              match;

    assign match    = occ && (slot_reg == ctrl.key_slot);
    assign hit_out  = hit_in | match;
    // insert point: first free cell or first later deadline (ties stay ahead)
    assign take     = !occ || (deadline_reg > ctrl.new_deadline);
    assign due      = occ && (deadline_reg <= ctrl.now);
    assign slot     = slot_reg;
    assign deadline = deadline_reg;

    always_comb
    begin
        slot_next     = slot_reg;
        deadline_next = deadline_reg;
        case (ctrl.op)
            OP_REMOVE:
            begin
                if (hit_out)
                begin
                    slot_next     = next_slot;
                    deadline_next = next_deadline;
                end
            end
            OP_INSERT:
            begin
                if (prev_take)
                begin
                    slot_next     = prev_slot;
                    deadline_next = prev_deadline;
                end
                else if (take)
                begin
                    slot_next     = ctrl.new_slot;
                    deadline_next = ctrl.new_deadline;
                end
            end
            OP_POP:
            begin
                slot_next     = next_slot;
                deadline_next = next_deadline;
            end
            default:
            begin
                slot_next     = slot_reg;
                deadline_next = deadline_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        deadline_reg <= deadline_next;
    end

endmodule

[design/deadline_timer_queue.sv]
// Deadline timer queue: sorted chain of cells, earliest deadline at cell 0.
// Abort: removed on the accept edge. Schedule: removed on the accept edge, then inserted.
// Tick: one expiry item per cycle out of cell 0, gated by the output register;
// a tick with nothing due returns to idle once it has checked the head.
// Reset (rst_n, async, active low) empties the queue and the output register;
// cell storage itself is not reset.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [SLOT_W-1:0] slot_id,
    input  logic [TIME_W-1:0] time_amount,
    input  logic [TIME_W-1:0] current_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SLOT_W-1:0] expired_slot,
    output logic [TIME_W-1:0] expired_deadline,
    output logic              last_flag
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    // sequencer state
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // pending schedule and tick time
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [TIME_W-1:0] pend_deadline_reg;
    logic [TIME_W-1:0] now_reg;

    // output register
    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [TIME_W-1:0] out_deadline_reg;
    logic              out_last_reg;

    logic              accept;
    logic              slot_ok;
    logic [TIME_W:0]   rel_sum;
    logic [TIME_W-1:0] sched_deadline;
    logic              pop;
    logic              pop_last;
    cell_ctrl_t        ctrl;

    // chain wiring
    logic [SLOT_W-1:0] cell_slot     [NUM_SLOTS];
    logic [TIME_W-1:0] cell_deadline [NUM_SLOTS];
    logic              cell_take     [NUM_SLOTS];
    logic              cell_hit      [NUM_SLOTS];
    logic              cell_due      [NUM_SLOTS];
    logic              cell_occ      [NUM_SLOTS];

    assign accept  = in_valid && in_ready;
    assign slot_ok = (32'(slot_id) < NUM_SLOTS);

    // relative deadline, saturating at the top of the time range
    assign rel_sum        = {1'b0, current_time} + {1'b0, time_amount};
    assign sched_deadline = (req_type == REQ_SCHED_REL)
                          ? (rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0])
                          : time_amount;

    // head pops only while output register is free or being drained
    assign pop      = (state_reg == ST_TICK) && cell_due[0]
                   && (!out_valid_reg || out_ready);
    assign pop_last = !(cell_occ[1] && cell_due[1]);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        in_ready          = 1'b0;
        ctrl.op           = OP_HOLD;
        ctrl.key_slot     = slot_id;
        ctrl.new_slot     = pend_slot_reg;
        ctrl.new_deadline = pend_deadline_reg;
        ctrl.now          = now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (slot_ok)
                    begin
                        // drop any existing entry of this slot on the accept edge
                        ctrl.op = OP_REMOVE;
                        if (cell_hit[NUM_SLOTS-1])
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        if (req_type != REQ_ABORT)
                        begin
                            state_next = ST_INSERT;
                        end
                    end
                end
            end
            ST_INSERT:
            begin
                if (32'(count_reg) < NUM_SLOTS)
                begin
                    ctrl.op    = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                if (!cell_due[0])
                begin
                    state_next = ST_IDLE;
                end
                else if (pop)
                begin
                    ctrl.op    = OP_POP;
                    count_next = count_reg - CNT_W'(1);
                    if (pop_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_slot_reg     <= slot_id;
            pend_deadline_reg <= sched_deadline;
            now_reg           <= current_time;
        end
        if (pop)
        begin
            out_slot_reg     <= cell_slot[0];
            out_deadline_reg <= cell_deadline[0];
            out_last_reg     <= pop_last;
        end
    end

    // cell chain
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        logic [SLOT_W-1:0] p_slot;
        logic [TIME_W-1:0] p_deadline;
        logic              p_take;
        logic              p_hit;
        logic [SLOT_W-1:0] n_slot;
        logic [TIME_W-1:0] n_deadline;

        assign cell_occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign p_slot     = cell_slot[i];
            assign p_deadline = cell_deadline[i];
            assign p_take     = 1'b0;
            assign p_hit      = 1'b0;
        end
        else
        begin : g_body
            assign p_slot     = cell_slot[i-1];
            assign p_deadline = cell_deadline[i-1];
            assign p_take     = cell_take[i-1];
            assign p_hit      = cell_hit[i-1];
        end

        if (i == NUM_SLOTS - 1)
        begin : g_tail
            assign n_slot     = cell_slot[i];
            assign n_deadline = cell_deadline[i];
        end
        else
        begin : g_inner
            assign n_slot     = cell_slot[i+1];
            assign n_deadline = cell_deadline[i+1];
        end

        dtq_cell u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .occ           (cell_occ[i]),
            .prev_slot     (p_slot),
            .prev_deadline (p_deadline),
            .prev_take     (p_take),
            .next_slot     (n_slot),
            .next_deadline (n_deadline),
            .hit_in        (p_hit),
            .slot          (cell_slot[i]),
            .deadline      (cell_deadline[i]),
            .take          (cell_take[i]),
            .hit_out       (cell_hit[i]),
            .due           (cell_due[i])
        );
    end

    assign out_valid        = out_valid_reg;
    assign expired_slot     = out_slot_reg;
    assign expired_deadline = out_deadline_reg;
    assign last_flag        = out_last_reg;

endmodule

[design/dtq_checker.sv]
// dtq_checker: port-level assertions for deadline_timer_queue, plus its bind.
// Depends on dtq_pkg.
module dtq_checker
    import dtq_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [REQ_W-1:0]  req_type,
    input logic [SLOT_W-1:0] slot_id,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SLOT_W-1:0] expired_slot,
    input logic [TIME_W-1:0] expired_deadline,
    input logic              last_flag
);

    // stalled expiry item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(expired_slot)
        && $stable(expired_deadline) && $stable(last_flag))
        else $error("stalled expiry item changed");

    // a schedule holds off the next item while it does the insert
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_SCHED_ABS || req_type == REQ_SCHED_REL)
        && (32'(slot_id) < NUM_SLOTS) |=> !in_ready)
        else $error("schedule did not hold off the next item");

    // a tick always scans the head before the next item
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_TICK) |=> !in_ready)
        else $error("tick did not hold off the next item");

    // mid-tick: more expiries pending, input stays blocked
    a_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_flag |-> !in_ready)
        else $error("input open before tick finished");

endmodule

bind deadline_timer_queue dtq_checker #(.NUM_SLOTS(NUM_SLOTS)) u_dtq_checker (.*);

[sim/deadline_timer_queue_tb.sv]
// Self-checking testbench for deadline_timer_queue: directed and random requests
// with random idling on both channels; a scoreboard class predicts every expiry.
// Depends on dtq_pkg and the deadline_timer_queue RTL.
`timescale 1ns / 1ps

module deadline_timer_queue_tb;
    import dtq_pkg::*;

    localparam int NUM_SLOTS    = DEF_NUM_SLOTS;
    localparam int RANDOM_ITEMS = 150;
    // Only catches a hang: the worst case (every item full of expiries, every one
    // stalled long) stays under this limit.
    localparam int CYCLE_LIMIT  = 1000000;
    // Quiet cycles after the last expected expiry, to catch stray output.
    localparam int DRAIN_CYCLES = 20;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot_id;
    logic [TIME_W-1:0] time_amount;
    logic [TIME_W-1:0] current_time;
    logic              out_valid;
    logic              out_ready;
    logic [SLOT_W-1:0] expired_slot;
    logic [TIME_W-1:0] expired_deadline;
    logic              last_flag;

    // One predicted expiry, as the block should emit it.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] deadline;
        logic              is_last;
    } expiry_t;

    // Keeps its own sorted copy of the queue and the expiries still awaited.
    class expiry_scoreboard;
        logic [SLOT_W-1:0] order_slot[$];
        logic [TIME_W-1:0] order_deadline[$];
        expiry_t           awaited[$];
        int                mismatches = 0;

        function int pending();
            return awaited.size();
        endfunction

        function void drop_slot(logic [SLOT_W-1:0] slot);
            int i;
            for (i = 0; i < order_slot.size(); i++)
            begin
                if (order_slot[i] == slot)
                begin
                    order_slot.delete(i);
                    order_deadline.delete(i);
                    break;
                end
            end
        endfunction

        function void note_request(req_t req, logic [SLOT_W-1:0] slot,
                                   logic [TIME_W-1:0] amount, logic [TIME_W-1:0] cur);
            int                due;
            int                pos;
            int                k;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] deadline;
            expiry_t           e;
            due = 0;
            pos = 0;
            if (req == REQ_TICK)
            begin
                while (due < order_slot.size() && order_deadline[due] <= cur)
                    due++;
                for (k = 0; k < due; k++)
                begin
                    e.slot     = order_slot[k];
                    e.deadline = order_deadline[k];
                    e.is_last  = (k == due - 1);
                    awaited.push_back(e);
                end
                repeat (due)
                begin
                    void'(order_slot.pop_front());
                    void'(order_deadline.pop_front());
                end
                return;
            end
            if (int'(slot) >= NUM_SLOTS)
                return;
            drop_slot(slot);
            if (req == REQ_ABORT)
                return;
            deadline = amount;
            if (req == REQ_SCHED_REL)
            begin
                sum      = {1'b0, cur} + {1'b0, amount};
                deadline = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
            end
            if (order_slot.size() >= NUM_SLOTS)
                return;
            // Equal deadlines keep arrival order: go past every entry <= new one.
            while (pos < order_slot.size() && order_deadline[pos] <= deadline)
                pos++;
            order_slot.insert(pos, slot);
            order_deadline.insert(pos, deadline);
        endfunction

        function void check_expiry(logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] deadline,
                                   logic is_last);
            expiry_t e;
            if (awaited.size() == 0)
            begin
                $error("unexpected expiry: slot %0d deadline %0d", slot, deadline);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (slot !== e.slot)
            begin
                $error("expired_slot: expected %0d, actual %0d", e.slot, slot);
                mismatches++;
            end
            if (deadline !== e.deadline)
            begin
                $error("expired_deadline: expected %0d, actual %0d", e.deadline, deadline);
                mismatches++;
            end
            if (is_last !== e.is_last)
            begin
                $error("last_flag: expected %0b, actual %0b", e.is_last, is_last);
                mismatches++;
            end
        endfunction
    endclass

    expiry_scoreboard sb = new();

    int               cycle_count   = 0;
    int               requests_sent = 0;
    // While set, neither side idles: back-to-back traffic on both channels.
    logic             calm          = 1'b0;
    logic [TIME_W-1:0] clock_us;

    deadline_timer_queue #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .slot_id          (slot_id),
        .time_amount      (time_amount),
        .current_time     (current_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .expired_slot     (expired_slot),
        .expired_deadline (expired_deadline),
        .last_flag        (last_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] rand_slot();
        return SLOT_W'($urandom_range(NUM_SLOTS - 1));
    endfunction

    // Present one request and hold it until accepted. If no gap follows,
    // in_valid stays high so the next call drives the next item in the
    // same time step without a second assignment to in_valid.
    task automatic send_request(input req_t req, input logic [SLOT_W-1:0] slot,
                                input logic [TIME_W-1:0] amount,
                                input logic [TIME_W-1:0] cur);
        int gap;
        in_valid     <= 1'b1;
        req_type     <= req;
        slot_id      <= slot;
        time_amount  <= amount;
        current_time <= cur;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(req, slot, amount, cur);
        requests_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: check every accepted expiry, then choose out_ready for the
    // next edge. Stalls are random in length, none while calm.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_expiry(expired_slot, expired_deadline, last_flag);
            if (calm)
            begin
                stall_left = 0;
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Hang guard.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int pick;
        int s;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        req_type     <= REQ_TICK;
        slot_id      <= '0;
        time_amount  <= '0;
        current_time <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part ----
        // Tick on an empty queue: nothing due, no output.
        send_request(REQ_TICK, rand_slot(), rand_time(), '0);
        // Abort of a slot that holds no entry.
        send_request(REQ_ABORT, 4'd5, rand_time(), rand_time());
        // Extreme deadlines on the extreme slots.
        send_request(REQ_SCHED_ABS, 4'd15, '0, rand_time());
        send_request(REQ_SCHED_ABS, 4'd0, TIME_MAX, rand_time());
        // Equal deadlines: slot 7 must queue behind slot 3.
        send_request(REQ_SCHED_ABS, 4'd3, 63'd100, rand_time());
        send_request(REQ_SCHED_ABS, 4'd7, 63'd100, rand_time());
        // Reschedule a queued slot to an earlier deadline.
        send_request(REQ_SCHED_ABS, 4'd3, 63'd50, rand_time());
        // Relative overflow saturates at the maximum, behind slot 0.
        send_request(REQ_SCHED_REL, 4'd9, TIME_MAX, TIME_MAX);
        // Relative landing on an existing deadline.
        send_request(REQ_SCHED_REL, 4'd4, 63'd10, 63'd90);
        send_request(REQ_ABORT, 4'd7, rand_time(), rand_time());
        // Partial expiry, then the entry exactly at the tick time.
        send_request(REQ_TICK, rand_slot(), rand_time(), 63'd99);
        send_request(REQ_TICK, rand_slot(), rand_time(), 63'd100);
        // Time running backwards: nothing due.
        send_request(REQ_TICK, rand_slot(), rand_time(), '0);
        // Relative with zero timeout near the top of the range.
        send_request(REQ_SCHED_REL, 4'd12, '0, TIME_MAX - 63'd1);
        // Everything is due at the maximum time.
        send_request(REQ_TICK, rand_slot(), rand_time(), TIME_MAX);

        // ---- Random part ----
        // Mostly requests around a running clock so ticks keep expiring
        // entries; a few full-queue bursts and some pure noise.
        clock_us = rand_time() >> 2;
        s = requests_sent;
        while (requests_sent - s < RANDOM_ITEMS)
        begin
            calm = (requests_sent - s > 60) && (requests_sent - s < 100);
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                // Fill every slot with near-equal deadlines, then expire all.
                for (int n = 0; n < NUM_SLOTS; n++)
                    send_request(REQ_SCHED_ABS, SLOT_W'(n),
                                 clock_us + TIME_W'($urandom_range(3)), rand_time());
                clock_us = clock_us + TIME_W'(3);
                send_request(REQ_TICK, rand_slot(), rand_time(), clock_us);
            end
            else if (pick < 38)
            begin
                send_request(REQ_SCHED_ABS, rand_slot(),
                             ($urandom_range(19) == 0) ? rand_time()
                                 : clock_us + TIME_W'($urandom_range(60)),
                             rand_time());
            end
            else if (pick < 58)
            begin
                send_request(REQ_SCHED_REL, rand_slot(),
                             ($urandom_range(9) == 0) ? rand_time()
                                 : TIME_W'($urandom_range(60)),
                             ($urandom_range(9) == 0) ? rand_time() : clock_us);
            end
            else if (pick < 68)
            begin
                send_request(REQ_ABORT, rand_slot(), rand_time(), rand_time());
            end
            else if (pick < 90)
            begin
                clock_us = clock_us + TIME_W'($urandom_range(30));
                send_request(REQ_TICK, rand_slot(), rand_time(), clock_us);
            end
            else
            begin
                send_request(req_t'($urandom_range(3)), rand_slot(), rand_time(),
                             rand_time());
            end
        end
        calm = 1'b0;

        // Flush whatever is left, saturated entries included.
        send_request(REQ_TICK, rand_slot(), rand_time(), TIME_MAX);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
